// ----- src/hae_pkg.sv -----
package hae_pkg;

    localparam int unsigned NameLen = 13;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [4:0] {
        ST_LINE    = 5'd0,
        ST_SKIP    = 5'd1,
        ST_CR      = 5'd2,
        ST_NAME_1  = 5'd3,
        ST_NAME_2  = 5'd4,
        ST_NAME_3  = 5'd5,
        ST_NAME_4  = 5'd6,
        ST_NAME_5  = 5'd7,
        ST_NAME_6  = 5'd8,
        ST_NAME_7  = 5'd9,
        ST_NAME_8  = 5'd10,
        ST_NAME_9  = 5'd11,
        ST_NAME_10 = 5'd12,
        ST_NAME_11 = 5'd13,
        ST_NAME_12 = 5'd14,
        ST_COLON   = 5'd15,
        ST_SP1     = 5'd16,
        ST_SCHEME  = 5'd17,
        ST_SP2     = 5'd18,
        ST_CRED    = 5'd19,
        ST_FOUND   = 5'd20,
        ST_NOHDR   = 5'd21
    } state_t;

    typedef enum logic [2:0] {
        K_SEARCH = 3'd0,
        K_SCHEME = 3'd1,
        K_SEND   = 3'd2,
        K_CRED   = 3'd3,
        K_FOUND  = 3'd4,
        K_NONE   = 3'd5
    } kind_t;

    // letter idx of "authorization", lower case
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "a";
            4'd1:    c = "u";
            4'd2:    c = "t";
            4'd3:    c = "h";
            4'd4:    c = "o";
            4'd5:    c = "r";
            4'd6:    c = "i";
            4'd7:    c = "z";
            4'd8:    c = "a";
            4'd9:    c = "t";
            4'd10:   c = "i";
            4'd11:   c = "o";
            4'd12:   c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[CH_UP_A:CH_UP_Z]})
        begin
            r = b + CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ----- src/hae_in_if.sv -----
interface hae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- src/hae_out_if.sv -----
interface hae_out_if import hae_pkg::*; ;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    kind_t      kind;
    logic       finished;

    modport source (output valid, output out_byte, output kind, output finished, input ready);
    modport sink   (input valid, input out_byte, input kind, input finished, output ready);
endinterface

// ----- src/http_authorization_header_extractor_top.sv -----
// Authorization header extractor.
// hdr carries one header byte per request (valid/ready). result carries one
// item per accepted byte: out_byte (the byte when tagged as scheme or
// credential, else 0), kind (search, scheme byte, scheme end, credential
// byte, found, no header) and finished (parser is in a terminal state).
// Latency: the result for a byte is presented the cycle after the byte is
// accepted, from a single output register.
// Throughput: one byte per cycle unless held by result.ready (see Stall); the
// parse state update is one small transition per byte, held in the state register.
// Reset: parser returns to line start and the output register is emptied.
// Stall: while a result waits on result.ready, hdr.ready stays low; the
// next byte is taken in the same cycle the held result is consumed.
// After found or no header, further bytes are still consumed and each
// repeats the terminal kind with finished set.
module http_authorization_header_extractor_top
    import hae_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    hae_in_if.sink          hdr,
    hae_out_if.source       result
);

    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    kind_t      kind_reg;
    logic       fin_reg;

    kind_t      kind_next;
    logic [7:0] echo_next;
    logic       fin_next;
    logic [7:0] b;
    logic [7:0] bf;
    logic [3:0] idx;
    logic       hdr_fire;

    assign b        = hdr.data_byte;
    assign bf       = fold_case(b);
    assign idx      = 4'(state_reg - ST_CR);
    assign hdr.ready = !out_valid_reg || result.ready;
    assign hdr_fire = hdr.valid && hdr.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_NAME_1, ST_NAME_2, ST_NAME_3, ST_NAME_4, ST_NAME_5, ST_NAME_6,
            ST_NAME_7, ST_NAME_8, ST_NAME_9, ST_NAME_10, ST_NAME_11, ST_NAME_12:
            begin
                if (bf == name_char(idx))
                    state_next = state_t'(state_reg + 5'd1);
                else if (b == CH_CR)
                    state_next = ST_CR;
                else
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (b == CH_CR)
                    state_next = ST_CR;
            end
            ST_CR:
            begin
                state_next = (b == CH_LF) ? ST_LINE : ST_SKIP;
            end
            ST_COLON:
            begin
                if (b == CH_COLON)
                    state_next = ST_SP1;
                else if (b == CH_CR)
                    state_next = ST_CR;
                else if (b != CH_SP)
                    state_next = ST_SKIP;
            end
            ST_SP1:
            begin
                if (b == CH_CR)
                    state_next = ST_FOUND;
                else if (b != CH_SP)
                    state_next = ST_SCHEME;
            end
            ST_SCHEME:
            begin
                if (b == CH_CR)
                    state_next = ST_FOUND;
                else if (b == CH_SP)
                    state_next = ST_SP2;
            end
            ST_SP2:
            begin
                if (b == CH_CR)
                    state_next = ST_FOUND;
                else if (b != CH_SP)
                    state_next = ST_CRED;
            end
            ST_CRED:
            begin
                if (b == CH_CR)
                    state_next = ST_FOUND;
            end
            ST_FOUND, ST_NOHDR:
            begin
                state_next = state_reg;
            end
            default:
            begin
                if (bf == name_char(4'd0))
                    state_next = ST_NAME_1;
                else if (b == CH_CR)
                    state_next = ST_NOHDR;
                else
                    state_next = ST_SKIP;
            end
        endcase
    end

    always_comb
    begin
        kind_next = K_SEARCH;
        echo_next = 8'h00;
        case (state_reg)
            ST_SP1:
            begin
                if (b == CH_CR)
                    kind_next = K_FOUND;
                else if (b != CH_SP)
                begin
                    kind_next = K_SCHEME;
                    echo_next = b;
                end
            end
            ST_SCHEME:
            begin
                if (b == CH_CR)
                    kind_next = K_FOUND;
                else if (b == CH_SP)
                    kind_next = K_SEND;
                else
                begin
                    kind_next = K_SCHEME;
                    echo_next = b;
                end
            end
            ST_SP2, ST_CRED:
            begin
                if (b == CH_CR)
                    kind_next = K_FOUND;
                else if (!(state_reg == ST_SP2 && b == CH_SP))
                begin
                    kind_next = K_CRED;
                    echo_next = b;
                end
            end
            ST_FOUND:
            begin
                kind_next = K_FOUND;
            end
            ST_NOHDR:
            begin
                kind_next = K_NONE;
            end
            ST_LINE:
            begin
                if (bf != name_char(4'd0) && b == CH_CR)
                    kind_next = K_NONE;
            end
            default:
            begin
                kind_next = K_SEARCH;
            end
        endcase
        fin_next = (state_next == ST_FOUND) || (state_next == ST_NOHDR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LINE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (hdr_fire)
                state_reg <= state_next;
            if (hdr.ready)
                out_valid_reg <= hdr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_fire)
        begin
            byte_reg <= echo_next;
            kind_reg <= kind_next;
            fin_reg  <= fin_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = byte_reg;
    assign result.kind     = kind_reg;
    assign result.finished = fin_reg;

`ifndef SYNTHESIS
    a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOUND |=> state_reg == ST_FOUND)
        else $error("found state left");

    a_nohdr_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NOHDR |=> state_reg == ST_NOHDR)
        else $error("no-header state left");

    a_fin_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.finished |-> result.kind == K_FOUND || result.kind == K_NONE)
        else $error("finished without terminal kind");

    a_untagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != K_SCHEME && result.kind != K_CRED
        |-> result.out_byte == 8'h00)
        else $error("untagged byte echoed");

    a_terminal_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_fire && state_reg == ST_FOUND |=> result.valid && result.kind == K_FOUND)
        else $error("terminal kind not repeated");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
    import hae_pkg::*;
;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       finished;
    } tag_t;

    typedef enum {
        END_NO_HEADER,
        END_AFTER_COLON,
        END_IN_SCHEME,
        END_BEFORE_CRED,
        END_IN_CRED
    } auth_end_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    localparam int unsigned IdleLimit   = 2000;
    localparam int unsigned TailCycles  = 10;
    localparam int unsigned HoldCycles  = 48;
    localparam int unsigned PrintLimit  = 200;
    localparam logic [8*13-1:0] AuthText = "authorization";

    logic clk;
    logic rst_n;

    hae_in_if  hdr ();
    hae_out_if result ();

    http_authorization_header_extractor_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr),
        .result (result)
    );

    state_t      parser_st = ST_LINE;
    tag_t        pending_tags[$];
    int unsigned sent_count  = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_hold     = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [7:0] auth_letter(input int unsigned idx);
        return AuthText[8*(NameLen-1-idx) +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= CH_UP_A && b <= CH_UP_Z)
        begin
            return b + CASE_GAP;
        end
        return b;
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= (CH_UP_A + CASE_GAP) && c <= (CH_UP_Z + CASE_GAP) && $urandom_range(0, 1) == 1)
        begin
            return c - CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == CH_CR);
        return v;
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == CH_CR || v == CH_SP);
        return v;
    endfunction

    // next-state and tag for one header byte
    function automatic tag_t parse_byte(input logic [7:0] b);
        tag_t   t;
        state_t nxt;
        t.out_byte = 8'h00;
        t.kind     = K_SEARCH;
        nxt        = parser_st;
        if (parser_st >= ST_NAME_1 && parser_st <= ST_NAME_12)
        begin
            if (to_lower(b) == auth_letter(parser_st - ST_NAME_1 + 1))
                nxt = state_t'(parser_st + 5'd1);
            else if (b == CH_CR)
                nxt = ST_CR;
            else
                nxt = ST_SKIP;
        end
        else
        begin
            case (parser_st)
                ST_SKIP:
                begin
                    if (b == CH_CR)
                        nxt = ST_CR;
                end
                ST_CR:
                begin
                    nxt = (b == CH_LF) ? ST_LINE : ST_SKIP;
                end
                ST_COLON:
                begin
                    if (b == CH_COLON)
                        nxt = ST_SP1;
                    else if (b == CH_CR)
                        nxt = ST_CR;
                    else if (b != CH_SP)
                        nxt = ST_SKIP;
                end
                ST_SP1:
                begin
                    if (b == CH_CR)
                    begin
                        nxt    = ST_FOUND;
                        t.kind = K_FOUND;
                    end
                    else if (b != CH_SP)
                    begin
                        nxt        = ST_SCHEME;
                        t.kind     = K_SCHEME;
                        t.out_byte = b;
                    end
                end
                ST_SCHEME:
                begin
                    if (b == CH_CR)
                    begin
                        nxt    = ST_FOUND;
                        t.kind = K_FOUND;
                    end
                    else if (b == CH_SP)
                    begin
                        nxt    = ST_SP2;
                        t.kind = K_SEND;
                    end
                    else
                    begin
                        t.kind     = K_SCHEME;
                        t.out_byte = b;
                    end
                end
                ST_SP2, ST_CRED:
                begin
                    if (b == CH_CR)
                    begin
                        nxt    = ST_FOUND;
                        t.kind = K_FOUND;
                    end
                    else if (!(parser_st == ST_SP2 && b == CH_SP))
                    begin
                        nxt        = ST_CRED;
                        t.kind     = K_CRED;
                        t.out_byte = b;
                    end
                end
                ST_FOUND:
                begin
                    t.kind = K_FOUND;
                end
                ST_NOHDR:
                begin
                    t.kind = K_NONE;
                end
                default:
                begin
                    if (to_lower(b) == auth_letter(0))
                        nxt = ST_NAME_1;
                    else if (b == CH_CR)
                    begin
                        nxt    = ST_NOHDR;
                        t.kind = K_NONE;
                    end
                    else
                        nxt = ST_SKIP;
                end
            endcase
        end
        t.finished = (nxt == ST_FOUND || nxt == ST_NOHDR);
        parser_st  = nxt;
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PrintLimit)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_header_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
        burst_left--;
        @(negedge clk);
        if (gap != 0)
        begin
            hdr.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr.valid     <= 1'b1;
        hdr.data_byte <= b;
        do @(posedge clk); while (!hdr.ready);
        pending_tags.push_back(parse_byte(b));
        sent_count++;
    endtask

    // keeps filler traffic out of the terminal states
    task automatic send_filler(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (parser_st == ST_LINE && v == CH_CR)
            v = CH_LF;
        else if (parser_st == ST_COLON && v == CH_COLON)
            v = CH_SP;
        send_header_byte(v);
    endtask

    task automatic idle_input();
        @(negedge clk);
        hdr.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        idle_input();
        while (pending_tags.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_line_rules();
        // LF at line start
        send_header_byte(CH_LF);
        send_header_byte(CH_CR);
        send_header_byte(CH_LF);
        // CR inside the name
        send_header_byte("a");
        send_header_byte("U");
        send_header_byte("t");
        send_header_byte("H");
        send_header_byte(CH_CR);
        send_header_byte(CH_LF);
        // byte extremes, CR followed by CR
        send_header_byte(8'hFF);
        send_header_byte(8'h00);
        send_header_byte(CH_CR);
        send_header_byte(CH_CR);
        send_header_byte(CH_LF);
        // non-LF after CR
        send_header_byte("@");
        send_header_byte(CH_CR);
        send_header_byte("Z");
        send_header_byte(CH_CR);
        send_header_byte(CH_LF);
    endtask

    task automatic test_header_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        int unsigned i;
        logic [7:0]  c;
        stop_at = sent_count + n;
        while (sent_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                begin
                    if (i == 0 && $urandom_range(0, 4) == 0)
                        c = auth_letter(0);
                    else
                        c = 8'(auth_letter(0) + $urandom_range(0, 25));
                    send_filler(mixed_case(c));
                end
                repeat ($urandom_range(0, 1)) send_filler(CH_SP);
                send_filler(CH_COLON);
                send_filler(CH_SP);
                repeat ($urandom_range(0, 16)) send_filler(value_byte());
                send_filler(CH_CR);
                send_filler(CH_LF);
            end
            else if (pick < 75)
            begin
                k = $urandom_range(1, NameLen);
                for (i = 0; i < k; i++)
                    send_filler(mixed_case(auth_letter(i)));
                if (k < NameLen)
                begin
                    if ($urandom_range(0, 3) == 0)
                        c = CH_CR;
                    else
                        do c = 8'($urandom_range(0, 255));
                        while (to_lower(c) == auth_letter(k) || c == CH_CR);
                end
                else
                begin
                    repeat ($urandom_range(0, 2)) send_filler(CH_SP);
                    if ($urandom_range(0, 3) == 0)
                        c = CH_CR;
                    else
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_COLON || c == CH_SP || c == CH_CR);
                end
                send_filler(c);
                if (c != CH_CR)
                begin
                    repeat ($urandom_range(0, 8)) send_filler(value_byte());
                    send_filler(CH_CR);
                end
                send_filler(CH_LF);
            end
            else
            begin
                repeat ($urandom_range(1, 12)) send_filler(8'($urandom_range(0, 255)));
                send_filler(CH_CR);
                send_filler(CH_LF);
            end
        end
    endtask

    task automatic test_backpressure();
        rx_hold = HoldCycles;
        send_filler("H");
        send_filler("o");
        send_filler("s");
        send_filler("t");
        send_filler(CH_COLON);
        send_filler(CH_SP);
        repeat (20) send_filler(value_byte());
        send_filler(CH_CR);
        send_filler(CH_LF);
    endtask

    task automatic test_drain_pause();
        wait_drain();
        test_header_traffic(12);
    endtask

    task automatic test_auth_field();
        auth_end_t   ending;
        int unsigned i;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       ending = END_NO_HEADER;
            1:       ending = END_AFTER_COLON;
            2:       ending = END_IN_SCHEME;
            3:       ending = END_BEFORE_CRED;
            default: ending = END_IN_CRED;
        endcase
        if (parser_st != ST_LINE)
        begin
            if (parser_st != ST_CR)
                send_header_byte(CH_CR);
            send_header_byte(CH_LF);
        end
        if (ending == END_NO_HEADER)
            send_header_byte(CH_CR);
        else
        begin
            for (i = 0; i < NameLen; i++)
                send_header_byte(mixed_case(auth_letter(i)));
            repeat ($urandom_range(0, 2)) send_header_byte(CH_SP);
            send_header_byte(CH_COLON);
            repeat ($urandom_range(0, 2)) send_header_byte(CH_SP);
            if (ending != END_AFTER_COLON)
            begin
                repeat ($urandom_range(1, 8)) send_header_byte(token_byte());
                if (ending != END_IN_SCHEME)
                begin
                    repeat ($urandom_range(1, 3)) send_header_byte(CH_SP);
                    if (ending == END_IN_CRED)
                    begin
                        send_header_byte(token_byte());
                        repeat ($urandom_range(8, 40)) send_header_byte(value_byte());
                    end
                end
            end
            send_header_byte(CH_CR);
        end
        // terminal state must ignore everything after
        repeat ($urandom_range(4, 10)) send_header_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        tag_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_tags.size() == 0)
                report_mismatch($sformatf("unexpected result byte=%02h kind=%0d finished=%0d",
                                          result.out_byte, result.kind, result.finished));
            else
            begin
                want = pending_tags.pop_front();
                if (result.out_byte !== want.out_byte || result.kind !== want.kind
                    || result.finished !== want.finished)
                    report_mismatch($sformatf("byte %02h/%02h kind %0d/%0d finished %0d/%0d",
                                              result.out_byte, want.out_byte,
                                              result.kind, want.kind,
                                              result.finished, want.finished));
            end
        end
    end

    initial
    begin
        rx_mode_t    mode;
        int unsigned phase_left;
        int unsigned tick;
        mode       = RX_ALWAYS;
        phase_left = 0;
        tick       = 0;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            tick++;
            if (rx_hold != 0)
            begin
                result.ready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(8, 64);
                end
                phase_left--;
                case (mode)
                    RX_ALWAYS:   result.ready <= 1'b1;
                    RX_RANDOM:   result.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: result.ready <= (tick % 4 != 3);
                    default:     result.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((hdr.valid && hdr.ready) || (result.valid && result.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        hdr.valid     = 1'b0;
        hdr.data_byte = 8'h00;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_line_rules();
        test_header_traffic(240);
        test_backpressure();
        test_header_traffic(120);
        test_drain_pause();
        test_header_traffic(100);
        test_auth_field();
        wait_drain();
        repeat (TailCycles) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- http_authorization_header_extractor_top.f -----
src/hae_pkg.sv
src/hae_in_if.sv
src/hae_out_if.sv
src/http_authorization_header_extractor_top.sv
tb/tb.sv
